// ===== sv/sau_pkg.sv =====
// ----------------------------------------------------------------------------
// sau_pkg: shared types and constants of the stack arithmetic unit
// Command and status codes, channel payloads and the request and status
// structs between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package sau_pkg;

  localparam int SAU_STACK_DEPTH = 16;
  localparam int SAU_WORD_WIDTH  = 32;

  typedef enum logic [2:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_ADD      = 3'd2,
    CMD_SUB      = 3'd3,
    CMD_MULT     = 3'd4,
    CMD_DIV      = 3'd5,
    CMD_ADD_ALL  = 3'd6,
    CMD_MULT_ALL = 3'd7
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_DIV_ZERO  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    cmd_code_t          command;
    logic signed [31:0] push_value;
  } sau_cmd_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic               top_valid;
    logic [4:0]         entry_count;
    status_t            status;
  } sau_rsp_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } alu_stat_t;

endpackage

// ===== sv/sau_if.sv =====
// ----------------------------------------------------------------------------
// sau_if: request and response channels of the stack arithmetic unit
// Valid/ready channels; a request moves at an edge with valid and ready high.
// ----------------------------------------------------------------------------
interface sau_cmd_if;
  logic              valid;
  logic              ready;
  sau_pkg::sau_cmd_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sau_rsp_if;
  logic              valid;
  logic              ready;
  sau_pkg::sau_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/sau_ram.sv =====
// ----------------------------------------------------------------------------
// sau_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sau_alu.sv =====
// ----------------------------------------------------------------------------
// sau_alu: shared iterative arithmetic unit
// One adder serves add, sub, shift-add multiply and restoring divide.
// ----------------------------------------------------------------------------
module sau_alu #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  sau_pkg::alu_req_t   req,
  input  logic [W-1:0]        x,
  input  logic [W-1:0]        y,
  output sau_pkg::alu_stat_t  stat,
  output logic [W-1:0]        result
);
  import sau_pkg::*;

  localparam int CW = $clog2(W + 1);

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_RUN  = 3'b010,
    U_FIX  = 3'b100
  } ustate_t;

  ustate_t       ustate;
  alu_op_t       op_r;
  logic [W-1:0]  acc;
  logic [W-1:0]  ma;
  logic [W-1:0]  mb;
  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic          neg;
  logic [CW-1:0] cnt;
  logic          done;

  logic [W-1:0]  op_a;
  logic [W-1:0]  op_b;
  logic          sub;
  logic [W:0]    sum;
  logic [W-1:0]  shifted;
  logic [W-1:0]  x_mag;
  logic [W-1:0]  y_mag;

  assign shifted = {rem[W-2:0], quo[W-1]};
  assign x_mag   = x[W-1] ? (~x + W'(1)) : x;
  assign y_mag   = y[W-1] ? (~y + W'(1)) : y;

  // Steer the one adder
  always_comb begin
    op_a = x;
    op_b = y;
    sub  = (req.op == ALU_SUB);
    unique case (ustate)
      U_IDLE: begin
        op_a = x;
        op_b = y;
        sub  = (req.op == ALU_SUB);
      end
      U_RUN: begin
        if (op_r == ALU_MUL) begin
          op_a = acc;
          op_b = ma;
          sub  = 1'b0;
        end else begin
          op_a = shifted;
          op_b = dvs;
          sub  = 1'b1;
        end
      end
      U_FIX: begin
        op_a = '0;
        op_b = quo;
        sub  = 1'b1;
      end
      default: begin
        op_a = x;
        op_b = y;
        sub  = 1'b0;
      end
    endcase
  end

  assign sum = {1'b0, op_a} + {1'b0, op_b ^ {W{sub}}} + {{W{1'b0}}, sub};

  always_ff @(posedge clk) begin
    if (rst) begin
      ustate <= U_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ustate)
        U_IDLE: begin
          if (req.start) begin
            op_r <= req.op;
            unique case (req.op)
              ALU_ADD, ALU_SUB: begin
                result <= sum[W-1:0];
                done   <= 1'b1;
              end
              ALU_MUL: begin
                acc    <= '0;
                ma     <= x;
                mb     <= y;
                cnt    <= CW'(W);
                ustate <= U_RUN;
              end
              ALU_DIV: begin
                rem    <= '0;
                quo    <= x_mag;
                dvs    <= y_mag;
                neg    <= x[W-1] ^ y[W-1];
                cnt    <= CW'(W);
                ustate <= U_RUN;
              end
              default: ustate <= U_IDLE;
            endcase
          end
        end
        U_RUN: begin
          if (op_r == ALU_MUL) begin
            if (mb[0]) begin
              acc <= sum[W-1:0];
            end
            ma <= {ma[W-2:0], 1'b0};
            mb <= {1'b0, mb[W-1:1]};
          end else if (sum[W]) begin
            rem <= sum[W-1:0];
            quo <= {quo[W-2:0], 1'b1};
          end else begin
            rem <= shifted;
            quo <= {quo[W-2:0], 1'b0};
          end
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            ustate <= U_FIX;
          end
        end
        U_FIX: begin
          // Multiply passes acc; divide applies the quotient sign through the adder
          if (op_r == ALU_MUL) begin
            result <= acc;
          end else begin
            result <= neg ? sum[W-1:0] : quo;
          end
          done   <= 1'b1;
          ustate <= U_IDLE;
        end
        default: ustate <= U_IDLE;
      endcase
    end
  end

  assign stat.done = done;
  assign stat.busy = (ustate != U_IDLE);

  a_start_when_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> (ustate == U_IDLE))
    else $error("alu started while busy");

  a_done_after_fix: assert property (@(posedge clk) disable iff (rst)
    (ustate == U_FIX) |=> (done && ustate == U_IDLE))
    else $error("alu did not finish after sign fix");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (ustate == U_IDLE))
    else $error("alu reported done while still running");

endmodule

// ===== sv/stack_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// stack_arithmetic_unit: operand stack of signed words with a command per step
// Push, pop, binary add/sub/mult/div and whole-stack add/mult folds, run by a
// small sequencer over one stack RAM and one shared iterative arithmetic unit.
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                                      | handshake
//   --------+-----+----------------------------------------------+----------
//   cmd     | in  | command, push_value                          | valid/ready
//   rsp     | out | top_value, top_valid, entry_count, status    | valid/ready
//
// Steps: the multiply and divide run one bit a cycle through the shared
//   adder in sau_alu; the folds fetch one entry at a time through the
//   single stack RAM read port, passing each through READ, FETCH and CALC.
// Reset: synchronous; clears the entry count, the sequencer and the response
//   valid. Stack RAM contents are not cleared; only live entries are read.
// Stalls: a finished response waits in the output register; the next request
//   is taken meanwhile, and the sequencer holds in DONE until the slot frees.
// ----------------------------------------------------------------------------
module stack_arithmetic_unit #(
  parameter int STACK_DEPTH = sau_pkg::SAU_STACK_DEPTH,
  parameter int WORD_WIDTH  = sau_pkg::SAU_WORD_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  sau_cmd_if.sink   cmd,
  sau_rsp_if.source rsp
);
  import sau_pkg::*;

  localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_FETCH = 6'b000100,
    S_CALC  = 6'b001000,
    S_WRITE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                state;
  cmd_code_t             cmd_r;
  status_t               status_r;
  logic                  pop_ok;
  logic [CNT_W-1:0]      count;
  logic [WORD_WIDTH-1:0] top_reg;   // mirror of the top stack entry
  logic [WORD_WIDTH-1:0] acc;       // fold accumulator, result or popped word
  logic [AW-1:0]         idx;       // RAM read pointer
  logic [AW-1:0]         wptr;      // RAM write pointer
  logic                  rsp_valid;
  sau_rsp_t              rsp_data;

  // Stack RAM
  logic                  ram_we;
  logic [WORD_WIDTH-1:0] rdata;

  // Shared unit
  alu_req_t              alu_req;
  alu_stat_t             alu_stat;
  logic [WORD_WIDTH-1:0] alu_x;
  logic [WORD_WIDTH-1:0] alu_y;
  logic [WORD_WIDTH-1:0] alu_res;

  logic [WORD_WIDTH+31:0] push_ext;
  logic [WORD_WIDTH-1:0]  push_word;
  logic [CNT_W-1:0]       cnt_m1;
  logic [CNT_W-1:0]       cnt_m2;
  logic                   fold_last;
  logic                   is_fold;
  logic [WORD_WIDTH-1:0]  out_word;
  logic [WORD_WIDTH+31:0] out_ext;
  logic [CNT_W+4:0]       cnt_ext;

  // Sign-extend the pushed word, then keep the low word bits
  assign push_ext  = {{WORD_WIDTH{cmd.data.push_value[31]}}, cmd.data.push_value};
  assign push_word = push_ext[WORD_WIDTH-1:0];

  assign cnt_m1    = count - CNT_W'(1);
  assign cnt_m2    = count - CNT_W'(2);
  assign fold_last = (CNT_W'(idx) == cnt_m1);
  assign is_fold   = (cmd_r == CMD_ADD_ALL) || (cmd_r == CMD_MULT_ALL);

  assign cmd.ready = (state == S_IDLE);
  assign ram_we    = (state == S_WRITE);

  sau_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr),
    .wdata (acc),
    .raddr (idx),
    .rdata (rdata)
  );

  // Pick the operation and operands for the shared unit; rdata holds the
  // entry fetched in READ. Sub is top minus next, div is next over top.
  always_comb begin
    alu_req.start = (state == S_FETCH) && (cmd_r != CMD_POP);
    alu_req.op    = ALU_ADD;
    alu_x         = top_reg;
    alu_y         = rdata;
    unique case (cmd_r)
      CMD_ADD: alu_req.op = ALU_ADD;
      CMD_SUB: alu_req.op = ALU_SUB;
      CMD_MULT: alu_req.op = ALU_MUL;
      CMD_DIV: begin
        alu_req.op = ALU_DIV;
        alu_x      = rdata;
        alu_y      = top_reg;
      end
      CMD_ADD_ALL: begin
        alu_req.op = ALU_ADD;
        alu_x      = acc;
      end
      CMD_MULT_ALL: begin
        alu_req.op = ALU_MUL;
        alu_x      = acc;
      end
      default: alu_req.op = ALU_ADD;
    endcase
  end

  sau_alu #(
    .W (WORD_WIDTH)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .x      (alu_x),
    .y      (alu_y),
    .stat   (alu_stat),
    .result (alu_res)
  );

  // Response fields: a good pop reports the popped word, else the new top, or zero when empty
  assign out_word = pop_ok ? acc : ((count != '0) ? top_reg : '0);
  assign out_ext  = {32'b0, out_word};
  assign cnt_ext  = {5'b0, count};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Drop the response on acceptance unless DONE reloads it this cycle
      if (rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_r    <= cmd.data.command;
            status_r <= ST_OK;
            pop_ok   <= 1'b0;
            unique case (cmd.data.command) inside
              CMD_PUSH: begin
                if (count == CNT_W'(STACK_DEPTH)) begin
                  status_r <= ST_OVERFLOW;
                  state    <= S_DONE;
                end else begin
                  acc   <= push_word;
                  wptr  <= count[AW-1:0];
                  state <= S_WRITE;
                end
              end
              CMD_POP: begin
                if (count == '0) begin
                  status_r <= ST_UNDERFLOW;
                  state    <= S_DONE;
                end else begin
                  // Hold the popped word; refetch the new top if one remains
                  pop_ok <= 1'b1;
                  acc    <= top_reg;
                  count  <= cnt_m1;
                  if (count >= CNT_W'(2)) begin
                    idx   <= cnt_m2[AW-1:0];
                    state <= S_READ;
                  end else begin
                    state <= S_DONE;
                  end
                end
              end
              CMD_ADD, CMD_SUB, CMD_MULT, CMD_DIV: begin
                if (count < CNT_W'(2)) begin
                  status_r <= ST_UNDERFLOW;
                  state    <= S_DONE;
                end else if (cmd.data.command == CMD_DIV && top_reg == '0) begin
                  status_r <= ST_DIV_ZERO;
                  state    <= S_DONE;
                end else begin
                  idx   <= cnt_m2[AW-1:0];
                  wptr  <= cnt_m2[AW-1:0];
                  state <= S_READ;
                end
              end
              CMD_ADD_ALL: begin
                // An empty stack pushes zero straight away
                acc   <= '0;
                idx   <= '0;
                wptr  <= '0;
                state <= (count == '0) ? S_WRITE : S_READ;
              end
              CMD_MULT_ALL: begin
                if (count == '0) begin
                  status_r <= ST_UNDERFLOW;
                  state    <= S_DONE;
                end else begin
                  acc   <= WORD_WIDTH'(1);
                  idx   <= '0;
                  wptr  <= '0;
                  state <= S_READ;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (cmd_r == CMD_POP) begin
            top_reg <= rdata;
            state   <= S_DONE;
          end else begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (alu_stat.done) begin
            acc <= alu_res;
            if (is_fold && !fold_last) begin
              idx   <= idx + AW'(1);
              state <= S_READ;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_WRITE: begin
          top_reg <= acc;
          unique case (cmd_r) inside
            CMD_PUSH:                  count <= count + CNT_W'(1);
            CMD_ADD_ALL, CMD_MULT_ALL: count <= CNT_W'(1);
            default:                   count <= cnt_m1;
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          // Load the response once the output register is free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid            <= 1'b1;
            rsp_data.top_value   <= $signed(out_ext[31:0]);
            rsp_data.top_valid   <= pop_ok || (count != '0);
            rsp_data.entry_count <= cnt_ext[4:0];
            rsp_data.status      <= status_r;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    (ram_we && cmd_r == CMD_PUSH) |-> (count < CNT_W'(STACK_DEPTH)))
    else $error("push written into a full stack");

  a_alu_idle_on_ready: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> !alu_stat.busy)
    else $error("request taken while the arithmetic unit is busy");

  a_done_only_in_calc: assert property (@(posedge clk) disable iff (rst)
    alu_stat.done |-> (state == S_CALC))
    else $error("arithmetic result outside the calc step");

  a_done_loads_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!rsp_valid || rsp.ready)) |=> (rsp_valid && state == S_IDLE))
    else $error("response not loaded on completion");

endmodule
